// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file smf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property sampled on the rising clock edge, off while reset is low.
`define SMF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Antecedent in one cycle, consequent required in the next cycle.
`define SMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/smf_pkg.sv =====
package smf_pkg;

	localparam int DATA_W      = 16;
	localparam int WINDOW_SIZE = 5;
	localparam int IDX_W       = $clog2(WINDOW_SIZE);
	localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
	localparam int MEDIAN_RANK = WINDOW_SIZE / 2;

	typedef logic [WINDOW_SIZE-1:0][DATA_W-1:0] window_t;

endpackage

// ===== rtl/sliding_median_filter.sv =====
// Running median filter over the last WINDOW_SIZE 16-bit samples. One sample
// request is taken every clock cycle while sample_ready is high, and each gives
// one result request: the sample enters the ring window at the first stage,
// and a rank network of WINDOW_SIZE*(WINDOW_SIZE-1) comparators picks the median
// of that window on its way into the result register. Until WINDOW_SIZE samples
// have arrived since reset, filtered carries the raw sample and ready_res is 0;
// from then on filtered is the upper median of the window and ready_res is 1.
// Backpressure on the result side stalls the sample side only once both the
// first stage and the result register are occupied.
module sliding_median_filter
	import smf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  logic [DATA_W-1:0] sample,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [DATA_W-1:0] filtered,
	output logic              ready_res
);

	window_t           window_q;
	logic [IDX_W-1:0]  wr_q;
	logic [CNT_W-1:0]  fill_q;
	logic              valid_s1;
	logic              full_s1;
	logic [DATA_W-1:0] sample_s1;
	logic              result_valid_q;
	logic [DATA_W-1:0] filtered_q;
	logic              ready_res_q;
	logic [DATA_W-1:0] median;
	logic              accept_in;
	logic              adv_s1;
	logic              full_now;

	assign adv_s1       = valid_s1 && (!result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || adv_s1;
	assign accept_in    = sample_valid && sample_ready;
	assign full_now     = (fill_q >= CNT_W'(WINDOW_SIZE - 1));

	always_ff @(posedge clk) begin
		if (accept_in) begin
			window_q[wr_q] <= sample;
			sample_s1      <= sample;
			full_s1        <= full_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept_in) begin
				wr_q <= (wr_q == IDX_W'(WINDOW_SIZE - 1)) ? '0 : wr_q + IDX_W'(1);
				if (fill_q != CNT_W'(WINDOW_SIZE)) begin
					fill_q <= fill_q + CNT_W'(1);
				end
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	smf_median u_median (
		.window (window_q),
		.median (median)
	);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			filtered_q  <= full_s1 ? median : sample_s1;
			ready_res_q <= full_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign filtered     = filtered_q;
	assign ready_res    = ready_res_q;

endmodule

// ===== rtl/smf_median.sv =====
module smf_median
	import smf_pkg::*;
(
	input  window_t             window,
	output logic [DATA_W-1:0]   median
);

	logic [WINDOW_SIZE-1:0][WINDOW_SIZE-1:0] below;
	logic [WINDOW_SIZE-1:0]                  hit;

	// Each element is ranked by how many others sort ahead of it; equal values
	// are ordered by position so that every rank occurs exactly once.
	always_comb begin
		below = '0;
		hit   = '0;
		median = '0;
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			for (int j = 0; j < WINDOW_SIZE; j++) begin
				if (j != i) begin
					below[i][j] = (window[j] < window[i]) ||
						((window[j] == window[i]) && (j < i));
				end
			end
			hit[i] = (IDX_W'($countones(below[i])) == IDX_W'(MEDIAN_RANK));
			median = median | (window[i] & {DATA_W{hit[i]}});
		end
	end

endmodule

// ===== rtl/smf_checker.sv =====
`include "assert_macros.svh"

module smf_checker
	import smf_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_ready,
	input logic [DATA_W-1:0] sample,
	input logic              result_valid,
	input logic              result_ready,
	input logic [DATA_W-1:0] filtered,
	input logic              ready_res
);

	// A stalled sample request keeps its payload.
	`SMF_ASSERT_NEXT(a_sample_hold, clk, arst_n, sample_valid && !sample_ready, sample_valid && $stable(sample))

	// A stalled result keeps its contents.
	`SMF_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(filtered) && $stable(ready_res))

	// Once a result reports the window full, results stay full while result_valid stays high.
	`SMF_ASSERT_NEXT(a_full_sticky, clk, arst_n, result_valid && ready_res, !result_valid || ready_res)

	// A new result in an empty slot comes from a request that left the first stage unstalled.
	`SMF_ASSERT(a_result_source, clk, arst_n, $rose(result_valid) |-> $past(sample_valid && sample_ready, 2))

endmodule

bind sliding_median_filter smf_checker u_smf_checker (.*);
